// ----- rtl/kdlpe_pkg.sv -----
package kdlpe_pkg;

    // default sizes
    localparam int NUM_KEYS_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    // fixed field widths
    localparam int KEY_BITS   = 4;
    localparam int CODE_W     = 4;
    localparam int CNT_OUT_W  = 3;
    localparam int QCOUNT_W   = 4;
    localparam int DEB_W      = 8;
    localparam int HOLD_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [HOLD_W-1:0] HOLD_SAT    = 16'd60000;
    localparam logic [DEB_W-1:0]  DEB_RESET   = 8'd2;
    localparam logic [HOLD_W-1:0] LONG_RESET  = 16'd100;

    // item kinds carried by the mode field
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } cfg_idx_t;

    // what one key lane found on a tick
    typedef struct packed {
        logic fire;
        logic is_long;
    } lane_evt_t;

    // one result beat
    typedef struct packed {
        logic [CODE_W-1:0]    event_code;
        logic [CNT_OUT_W-1:0] events_pushed;
        logic [CNT_OUT_W-1:0] events_dropped;
        logic [QCOUNT_W-1:0]  queue_count;
    } result_t;

endpackage

// ----- rtl/kdlpe_lane.sv -----
module kdlpe_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick_en,
    input  logic                         raw,
    input  logic [kdlpe_pkg::DEB_W-1:0]  debounce_ticks,
    input  logic [kdlpe_pkg::HOLD_W-1:0] long_press_ticks,
    output kdlpe_pkg::lane_evt_t         evt
);
    import kdlpe_pkg::*;

    logic              last_sample_reg,  last_sample_next;
    logic [DEB_W-1:0]  settle_count_reg, settle_count_next;
    logic              stable_level_reg, stable_level_next;
    logic [HOLD_W-1:0] hold_count_reg,   hold_count_next;
    logic              long_sent_reg,    long_sent_next;

    always_comb
    begin
        last_sample_next  = last_sample_reg;
        settle_count_next = settle_count_reg;
        stable_level_next = stable_level_reg;
        hold_count_next   = hold_count_reg;
        long_sent_next    = long_sent_reg;
        evt               = '0;

        if (raw != last_sample_reg)
        begin
            last_sample_next  = raw;
            settle_count_next = '0;
        end
        else if (settle_count_reg < debounce_ticks)
        begin
            settle_count_next = settle_count_reg + 1'b1;
        end
        else if (stable_level_reg != raw)
        begin
            stable_level_next = raw;
            if (raw)
            begin
                hold_count_next = '0;
                long_sent_next  = 1'b0;
            end
            else if (!long_sent_reg)
            begin
                // release without a long report gives a short event
                evt.fire    = 1'b1;
                evt.is_long = 1'b0;
            end
        end

        if (stable_level_next)
        begin
            if (hold_count_next < HOLD_SAT)
            begin
                hold_count_next = hold_count_next + 1'b1;
            end
            if ((hold_count_next >= long_press_ticks) && !long_sent_next)
            begin
                long_sent_next = 1'b1;
                evt.fire       = 1'b1;
                evt.is_long    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg  <= 1'b0;
            settle_count_reg <= '0;
            stable_level_reg <= 1'b0;
            hold_count_reg   <= '0;
            long_sent_reg    <= 1'b0;
        end
        else if (tick_en)
        begin
            last_sample_reg  <= last_sample_next;
            settle_count_reg <= settle_count_next;
            stable_level_reg <= stable_level_next;
            hold_count_reg   <= hold_count_next;
            long_sent_reg    <= long_sent_next;
        end
    end

endmodule

// ----- rtl/kdlpe_queue.sv -----
module kdlpe_queue #(
    parameter int NUM_KEYS    = kdlpe_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = kdlpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_en,
    input  logic                 pop_en,
    input  kdlpe_pkg::lane_evt_t evts [NUM_KEYS],
    output kdlpe_pkg::result_t   res
);
    import kdlpe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(NUM_KEYS + 1);
    localparam logic [PTR_W:0]   DEPTH_W1 = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    logic [CODE_W-1:0] event_store_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg,  read_ptr_next;

    logic [PTR_W-1:0]  wr_addr [NUM_KEYS];
    logic [CODE_W-1:0] wr_code [NUM_KEYS];
    logic              wr_en   [NUM_KEYS];

    logic [PTR_W:0]    diff;
    logic [PTR_W:0]    sum;
    logic [PTR_W-1:0]  len;
    logic [PTR_W-1:0]  free_slots;
    logic [PTR_W-1:0]  slot;
    logic [CNT_W-1:0]  drop;
    logic [PTR_W-1:0]  count_next;

    always_comb
    begin
        diff = {1'b0, write_ptr_reg} - {1'b0, read_ptr_reg};
        if (write_ptr_reg < read_ptr_reg)
        begin
            diff = diff + DEPTH_W1;
        end
        len        = diff[PTR_W-1:0];
        free_slots = LAST_IDX - len;

        slot = '0;
        drop = '0;
        // keys claim slots in index order, the rest are dropped
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            wr_en[k]   = 1'b0;
            wr_code[k] = CODE_W'(2 * k + (evts[k].is_long ? 2 : 1));
            sum        = {1'b0, write_ptr_reg} + {1'b0, slot};
            if (sum >= DEPTH_W1)
            begin
                sum = sum - DEPTH_W1;
            end
            wr_addr[k] = sum[PTR_W-1:0];
            if (tick_en && evts[k].fire)
            begin
                if (slot < free_slots)
                begin
                    wr_en[k] = 1'b1;
                    slot     = slot + 1'b1;
                end
                else
                begin
                    drop = drop + 1'b1;
                end
            end
        end

        sum = {1'b0, write_ptr_reg} + {1'b0, slot};
        if (sum >= DEPTH_W1)
        begin
            sum = sum - DEPTH_W1;
        end
        write_ptr_next = sum[PTR_W-1:0];

        read_ptr_next  = read_ptr_reg;
        res            = '0;
        count_next     = len + slot;
        if (pop_en && (len != '0))
        begin
            res.event_code = event_store_mem[read_ptr_reg];
            read_ptr_next  = (read_ptr_reg == LAST_IDX) ? '0 : read_ptr_reg + 1'b1;
            count_next     = len - 1'b1;
        end
        res.events_pushed  = CNT_OUT_W'(slot);
        res.events_dropped = CNT_OUT_W'(drop);
        res.queue_count    = QCOUNT_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (wr_en[k])
            begin
                event_store_mem[wr_addr[k]] <= wr_code[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg <= '0;
            read_ptr_reg  <= '0;
        end
        else
        begin
            if (tick_en)
            begin
                write_ptr_reg <= write_ptr_next;
            end
            if (pop_en)
            begin
                read_ptr_reg <= read_ptr_next;
            end
        end
    end

endmodule

// ----- rtl/key_debounce_long_press_events_unit.sv -----
// channel   direction  handshake               payload
// cfg       in         cfg_we (no wait)        cfg_index, cfg_data
// in        in         in_valid / in_ready     mode, key_pressed
// out       out        out_valid / out_ready   event_code, events_pushed,
//                                              events_dropped, queue_count
//
// one beat in, one beat out; a beat's result is registered in the main or skid entry
// sustained rate is one beat per cycle while out_ready holds: all key lanes and
// the queue writes for a tick settle in the single accept cycle
// reset (rst_n low) clears the key state, the queue pointers and the output
// stages; the registers return to debounce 2, long press 100
// a two-entry output stage (main plus skid) lets input keep flowing while a
// result waits; in_ready drops only when both entries are full
module key_debounce_long_press_events_unit #(
    parameter int NUM_KEYS    = kdlpe_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = kdlpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [kdlpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kdlpe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [kdlpe_pkg::KEY_BITS-1:0]       key_pressed,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [kdlpe_pkg::CODE_W-1:0]         event_code,
    output logic [kdlpe_pkg::CNT_OUT_W-1:0]      events_pushed,
    output logic [kdlpe_pkg::CNT_OUT_W-1:0]      events_dropped,
    output logic [kdlpe_pkg::QCOUNT_W-1:0]       queue_count
);
    import kdlpe_pkg::*;

    // configuration registers
    logic [DEB_W-1:0]  debounce_ticks_reg;
    logic [HOLD_W-1:0] long_press_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEB_RESET;
            long_press_ticks_reg <= LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:   debounce_ticks_reg   <= cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS: long_press_ticks_reg <= cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    // accept and item kind
    logic accept;
    logic tick_en;
    logic pop_en;

    assign accept  = in_valid && in_ready;
    assign tick_en = accept && (mode == MODE_TICK);
    assign pop_en  = accept && (mode == MODE_POP);

    // one debounce / hold lane per key; keys past the input width read released
    lane_evt_t evts [NUM_KEYS];

    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_lane
        logic raw;
        if (i < KEY_BITS)
        begin : g_pin
            assign raw = key_pressed[i];
        end
        else
        begin : g_none
            assign raw = 1'b0;
        end

        kdlpe_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .tick_en          (tick_en),
            .raw              (raw),
            .debounce_ticks   (debounce_ticks_reg),
            .long_press_ticks (long_press_ticks_reg),
            .evt              (evts[i])
        );
    end

    // merge: queue the lane events in key order, or pop one
    result_t res;

    kdlpe_queue #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick_en (tick_en),
        .pop_en  (pop_en),
        .evts    (evts),
        .res     (res)
    );

    // output stage: main register plus skid entry
    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (accept)
            begin
                main_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            // skid drains first; it cannot be full while a beat is accepted
            main_valid_reg <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    assign out_valid      = main_valid_reg;
    assign event_code     = main_reg.event_code;
    assign events_pushed  = main_reg.events_pushed;
    assign events_dropped = main_reg.events_dropped;
    assign queue_count    = main_reg.queue_count;

endmodule

// ----- rtl/kdlpe_checker.sv -----
module kdlpe_checker #(
    parameter int QUEUE_DEPTH = kdlpe_pkg::QUEUE_DEPTH_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [kdlpe_pkg::CODE_W-1:0]     event_code,
    input logic [kdlpe_pkg::CNT_OUT_W-1:0]  events_pushed,
    input logic [kdlpe_pkg::CNT_OUT_W-1:0]  events_dropped,
    input logic [kdlpe_pkg::QCOUNT_W-1:0]   queue_count
);
    import kdlpe_pkg::*;

    localparam logic [QCOUNT_W-1:0] FULL_COUNT = QCOUNT_W'(QUEUE_DEPTH - 1);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code)
            && $stable(queue_count))
        else $error("stalled result beat changed");

    // a beat that queued events came from a tick, so it pops nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (events_pushed != '0) |-> (event_code == '0))
        else $error("pushes and a pop in one beat");

    // drops only happen once the ring is full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (events_dropped != '0) |-> (queue_count == FULL_COUNT))
        else $error("event dropped while the queue had room");

    // input stalls only when both output entries hold a result, so out_valid is high
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty output stage");

endmodule

bind key_debounce_long_press_events_unit kdlpe_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_kdlpe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_code     (event_code),
    .events_pushed  (events_pushed),
    .events_dropped (events_dropped),
    .queue_count    (queue_count)
);
